@@ rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a implies condition b in the same cycle.
`define ASSERT_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// Condition a implies condition b in the next cycle.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

@@ rtl/ese_pkg.sv @@
// Types and character constants for the escape sequence expander.
package ese_pkg;

  // Decoder mode, one-hot
  typedef enum logic [4:0] {
    MODE_NORMAL = 5'b00001,
    MODE_ESC    = 5'b00010,
    MODE_HEX    = 5'b00100,
    MODE_OCT1   = 5'b01000,
    MODE_OCT2   = 5'b10000
  } mode_t;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUESTION  = 8'h3F;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_SEVEN     = 8'h37;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_LA        = 8'h61;
  localparam logic [7:0] CH_LB        = 8'h62;
  localparam logic [7:0] CH_LF        = 8'h66;
  localparam logic [7:0] CH_LN        = 8'h6E;
  localparam logic [7:0] CH_LR        = 8'h72;
  localparam logic [7:0] CH_LT        = 8'h74;
  localparam logic [7:0] CH_LV        = 8'h76;
  localparam logic [7:0] CH_LX        = 8'h78;
  localparam logic [7:0] CH_UA        = 8'h41;
  localparam logic [7:0] CH_UF        = 8'h46;

  localparam logic [7:0] VAL_BELL      = 8'h07;
  localparam logic [7:0] VAL_BACKSPACE = 8'h08;
  localparam logic [7:0] VAL_FORMFEED  = 8'h0C;
  localparam logic [7:0] VAL_NEWLINE   = 8'h0A;
  localparam logic [7:0] VAL_RETURN    = 8'h0D;
  localparam logic [7:0] VAL_TAB       = 8'h09;
  localparam logic [7:0] VAL_VTAB      = 8'h0B;
  localparam logic [7:0] VAL_DELETE    = 8'h7F;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       string_end;
  } out_item_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] hex_value;
    logic [2:0] octal_first;
    logic [2:0] octal_second;
  } dec_state_t;

  // Decode of one source byte: next state and up to three bytes
  typedef struct packed {
    dec_state_t      state_next;
    logic [2:0][7:0] out_bytes;
    logic [1:0]      count;
  } step_t;

endpackage

@@ rtl/ese_stream_if.sv @@
// Valid/ready stream channel with a typed payload.
interface ese_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/escape_sequence_expander.sv @@
// Top level: C backslash escape expander on a byte stream.
//
//   channel  direction  payload
//   src      in         in_byte[7:0], last_byte
//   dst      out        out_byte[7:0], run_end, string_end
//
// A source byte is decoded in the cycle it transfers; its 0 to 3 result bytes
// sit in a three-entry result register and leave one per cycle from the next
// cycle on. A byte that yields one result or none sustains one byte per
// cycle while dst is ready; a byte that yields more holds src until its last
// result leaves, set by the single output port draining the result register.
// Reset (rst, synchronous) returns the decoder to normal mode and empties the
// result register. A stall on dst holds the result register and src.
module escape_sequence_expander (
  input  logic         clk,
  input  logic         rst,
  ese_stream_if.sink   src,
  ese_stream_if.source dst
);
  import ese_pkg::*;

  dec_state_t      state;
  step_t           step;
  logic [2:0][7:0] res_bytes;
  logic [1:0]      res_count;
  logic            res_last;
  logic            pop;
  logic            load;
  ese_pkg::in_item_t item;

  assign item = src.payload;

  ese_step u_step (
    .state (state),
    .item  (item),
    .step  (step)
  );

  assign pop       = dst.valid && dst.ready;
  assign src.ready = (res_count == 2'd0) || ((res_count == 2'd1) && dst.ready);
  assign load      = src.valid && src.ready;

  // Present the head of the result register
  assign dst.valid              = (res_count != 2'd0);
  assign dst.payload.out_byte   = res_bytes[0];
  assign dst.payload.run_end    = (res_count == 2'd1);
  assign dst.payload.string_end = (res_count == 2'd1) && res_last;

  // Decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode         <= MODE_NORMAL;
      state.hex_value    <= 8'd0;
      state.octal_first  <= 3'd0;
      state.octal_second <= 3'd0;
    end else if (load) begin
      state <= step.state_next;
    end
  end

  // Result count: load a new run or drop the transferred byte
  always_ff @(posedge clk) begin
    if (rst) begin
      res_count <= 2'd0;
    end else if (load) begin
      res_count <= step.count;
    end else if (pop) begin
      res_count <= res_count - 2'd1;
    end
  end

  // Result bytes: load or shift toward the head
  always_ff @(posedge clk) begin
    if (load) begin
      res_bytes <= step.out_bytes;
      res_last  <= item.last_byte;
    end else if (pop) begin
      res_bytes[0] <= res_bytes[1];
      res_bytes[1] <= res_bytes[2];
    end
  end

endmodule

@@ rtl/ese_step.sv @@
// Decode of one source byte against the current escape state.
module ese_step (
  input  ese_pkg::dec_state_t state,
  input  ese_pkg::in_item_t   item,
  output ese_pkg::step_t      step
);
  import ese_pkg::*;

  logic       is_oct;
  logic       is_hex;
  logic [3:0] hex_d;
  logic [7:0] b;

  assign b = item.in_byte;

  // Classify the byte
  always_comb begin
    is_oct = (b >= CH_ZERO) && (b <= CH_SEVEN);
    is_hex = 1'b1;
    hex_d  = 4'd0;
    priority if ((b >= CH_ZERO) && (b <= CH_NINE)) begin
      hex_d = 4'(b - CH_ZERO);
    end else if ((b >= CH_LA) && (b <= CH_LF)) begin
      hex_d = 4'(b - CH_LA + 8'd10);
    end else if ((b >= CH_UA) && (b <= CH_UF)) begin
      hex_d = 4'(b - CH_UA + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  // Advance the state and collect the emitted bytes
  always_comb begin
    logic       do_plain;
    logic [1:0] n;
    dec_state_t s;
    logic [2:0][7:0] ob;

    s        = state;
    n        = 2'd0;
    ob       = '0;
    do_plain = 1'b0;

    unique case (state.mode)
      MODE_ESC: begin
        s.mode = MODE_NORMAL;
        priority case (b)
          CH_LA:        begin ob[n] = VAL_BELL;      n = n + 2'd1; end
          CH_LB:        begin ob[n] = VAL_BACKSPACE; n = n + 2'd1; end
          CH_LF:        begin ob[n] = VAL_FORMFEED;  n = n + 2'd1; end
          CH_LN:        begin ob[n] = VAL_NEWLINE;   n = n + 2'd1; end
          CH_LR:        begin ob[n] = VAL_RETURN;    n = n + 2'd1; end
          CH_LT:        begin ob[n] = VAL_TAB;       n = n + 2'd1; end
          CH_LV:        begin ob[n] = VAL_VTAB;      n = n + 2'd1; end
          CH_BACKSLASH: begin ob[n] = CH_BACKSLASH;  n = n + 2'd1; end
          CH_QUESTION:  begin ob[n] = VAL_DELETE;    n = n + 2'd1; end
          CH_LX: begin
            s.mode      = MODE_HEX;
            s.hex_value = 8'd0;
          end
          default: begin
            if (is_oct) begin
              s.mode        = MODE_OCT1;
              s.octal_first = b[2:0];
            end else begin
              ob[n] = b;
              n     = n + 2'd1;
            end
          end
        endcase
      end
      MODE_HEX: begin
        if (is_hex) begin
          s.hex_value = {state.hex_value[3:0], hex_d};
        end else begin
          ob[n]    = state.hex_value;
          n        = n + 2'd1;
          s.mode   = MODE_NORMAL;
          do_plain = 1'b1;
        end
      end
      MODE_OCT1: begin
        if (is_oct) begin
          s.octal_second = b[2:0];
          s.mode         = MODE_OCT2;
        end else begin
          ob[n]    = CH_ZERO | {5'd0, state.octal_first};
          n        = n + 2'd1;
          s.mode   = MODE_NORMAL;
          do_plain = 1'b1;
        end
      end
      MODE_OCT2: begin
        s.mode = MODE_NORMAL;
        if (is_oct) begin
          ob[n] = {state.octal_first[1:0], state.octal_second, b[2:0]};
          n     = n + 2'd1;
        end else begin
          ob[n]    = CH_ZERO | {5'd0, state.octal_first};
          n        = n + 2'd1;
          ob[n]    = CH_ZERO | {5'd0, state.octal_second};
          n        = n + 2'd1;
          do_plain = 1'b1;
        end
      end
      default: begin
        s.mode   = MODE_NORMAL;
        do_plain = 1'b1;
      end
    endcase

    // Handle the byte as an ordinary character
    if (do_plain) begin
      if (b == CH_BACKSLASH) begin
        s.mode = MODE_ESC;
      end else begin
        ob[n] = b;
        n     = n + 2'd1;
      end
    end

    // Flush any pending escape on the last byte
    if (item.last_byte) begin
      unique case (s.mode)
        MODE_ESC: begin
          ob[n] = CH_BACKSLASH;
          n     = n + 2'd1;
        end
        MODE_HEX: begin
          ob[n] = s.hex_value;
          n     = n + 2'd1;
        end
        MODE_OCT1: begin
          ob[n] = CH_ZERO | {5'd0, s.octal_first};
          n     = n + 2'd1;
        end
        MODE_OCT2: begin
          ob[n] = CH_ZERO | {5'd0, s.octal_first};
          n     = n + 2'd1;
          ob[n] = CH_ZERO | {5'd0, s.octal_second};
          n     = n + 2'd1;
        end
        default: begin
        end
      endcase
      s.mode = MODE_NORMAL;
    end

    step.state_next = s;
    step.out_bytes  = ob;
    step.count      = n;
  end

endmodule

@@ rtl/ese_checker.sv @@
// Port-level checks for the escape sequence expander, bound to the top level.
`include "assert_macros.svh"

module ese_checker (
  input logic clk,
  input logic rst,
  input logic src_valid,
  input logic src_ready,
  input logic dst_valid,
  input logic dst_ready,
  input logic dst_run_end,
  input logic dst_string_end
);

  // A stalled result stays offered
  `ASSERT_NEXT(a_dst_hold, clk, rst, dst_valid && !dst_ready, dst_valid)

  // The end of a string also ends the run of its byte
  `ASSERT_SAME(a_end_nested, clk, rst, dst_valid && dst_string_end, dst_run_end)

  // A run continues right after a transfer that did not end it
  `ASSERT_NEXT(a_run_cont, clk, rst, dst_valid && dst_ready && !dst_run_end, dst_valid)

  // Source is held back only while results are waiting
  `ASSERT_SAME(a_src_stall, clk, rst, !src_ready, dst_valid && !(dst_run_end && dst_ready))

  // An input taken while results are offered is taken only as the last of them transfers
  `ASSERT_SAME(a_src_take, clk, rst, src_valid && src_ready && dst_valid, dst_run_end && dst_ready)

endmodule

bind escape_sequence_expander ese_checker u_ese_checker (
  .clk            (clk),
  .rst            (rst),
  .src_valid      (src.valid),
  .src_ready      (src.ready),
  .dst_valid      (dst.valid),
  .dst_ready      (dst.ready),
  .dst_run_end    (dst.payload.run_end),
  .dst_string_end (dst.payload.string_end)
);

@@ tb/escape_expansion_checker.sv @@
// Watches both channels of the escape sequence expander, predicts each result and compares.
module escape_expansion_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  input  logic               src_ready,
  input  ese_pkg::in_item_t  src_item,
  input  logic               dst_valid,
  input  logic               dst_ready,
  input  ese_pkg::out_item_t dst_item,
  output int                 error_count,
  output int                 results_due
);
  import ese_pkg::*;

  // Decoder state as the block should hold it
  mode_t      dec_mode;
  logic [7:0] hex_acc;
  logic [2:0] oct_hi;
  logic [2:0] oct_mid;

  // Bytes produced by the current source byte, and results still owed
  logic [7:0] step_q[$];
  out_item_t  expected_q[$];
  out_item_t  want;

  initial begin
    error_count = 0;
    results_due = 0;
  end

  function automatic bit is_octal(logic [7:0] b);
    return b >= CH_ZERO && b <= CH_SEVEN;
  endfunction

  function automatic void emit_char(logic [7:0] b);
    step_q.push_back(b);
  endfunction

  // Normal-mode handling: a backslash opens an escape, anything else passes
  function automatic void take_plain(logic [7:0] b);
    if (b == CH_BACKSLASH) begin
      dec_mode = MODE_ESC;
    end else begin
      emit_char(b);
    end
  endfunction

  // Decode one source byte and queue the results it causes
  function automatic void expand_source_byte(in_item_t item);
    logic [7:0] b;
    logic [3:0] nib;
    bit         hex_ok;
    out_item_t  res;
    b = item.in_byte;
    step_q.delete();

    // Classify as a hex digit
    hex_ok = 1'b1;
    nib = '0;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      nib = 4'(b - CH_ZERO);
    end else if (b >= CH_LA && b <= CH_LF) begin
      nib = 4'(b - CH_LA + 8'd10);
    end else if (b >= CH_UA && b <= CH_UF) begin
      nib = 4'(b - CH_UA + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end

    case (dec_mode)
      MODE_ESC: begin
        dec_mode = MODE_NORMAL;
        case (b)
          CH_LA:        emit_char(VAL_BELL);
          CH_LB:        emit_char(VAL_BACKSPACE);
          CH_LF:        emit_char(VAL_FORMFEED);
          CH_LN:        emit_char(VAL_NEWLINE);
          CH_LR:        emit_char(VAL_RETURN);
          CH_LT:        emit_char(VAL_TAB);
          CH_LV:        emit_char(VAL_VTAB);
          CH_BACKSLASH: emit_char(CH_BACKSLASH);
          CH_QUESTION:  emit_char(VAL_DELETE);
          CH_LX: begin
            dec_mode = MODE_HEX;
            hex_acc = '0;
          end
          default: begin
            if (is_octal(b)) begin
              dec_mode = MODE_OCT1;
              oct_hi = b[2:0];
            end else begin
              emit_char(b);
            end
          end
        endcase
      end
      MODE_HEX: begin
        // Accumulate digits; the first other byte ends the value
        if (hex_ok) begin
          hex_acc = {hex_acc[3:0], nib};
        end else begin
          emit_char(hex_acc);
          dec_mode = MODE_NORMAL;
          take_plain(b);
        end
      end
      MODE_OCT1: begin
        if (is_octal(b)) begin
          oct_mid = b[2:0];
          dec_mode = MODE_OCT2;
        end else begin
          emit_char(CH_ZERO | {5'b0, oct_hi});
          dec_mode = MODE_NORMAL;
          take_plain(b);
        end
      end
      MODE_OCT2: begin
        dec_mode = MODE_NORMAL;
        if (is_octal(b)) begin
          emit_char({oct_hi[1:0], oct_mid, b[2:0]});
        end else begin
          emit_char(CH_ZERO | {5'b0, oct_hi});
          emit_char(CH_ZERO | {5'b0, oct_mid});
          take_plain(b);
        end
      end
      default: begin
        dec_mode = MODE_NORMAL;
        take_plain(b);
      end
    endcase

    // Flush whatever escape is still open at the end of the string
    if (item.last_byte) begin
      case (dec_mode)
        MODE_ESC:  emit_char(CH_BACKSLASH);
        MODE_HEX:  emit_char(hex_acc);
        MODE_OCT1: emit_char(CH_ZERO | {5'b0, oct_hi});
        MODE_OCT2: begin
          emit_char(CH_ZERO | {5'b0, oct_hi});
          emit_char(CH_ZERO | {5'b0, oct_mid});
        end
        default: ;
      endcase
      dec_mode = MODE_NORMAL;
    end

    // Tag the final byte of this step
    foreach (step_q[i]) begin
      res.out_byte   = step_q[i];
      res.run_end    = (i == step_q.size() - 1);
      res.string_end = item.last_byte && (i == step_q.size() - 1);
      expected_q.push_back(res);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      dec_mode = MODE_NORMAL;
      hex_acc = '0;
      oct_hi = '0;
      oct_mid = '0;
      expected_q.delete();
    end else begin
      // Predict on each source transfer
      if (src_valid && src_ready) begin
        expand_source_byte(src_item);
      end
      // Compare each result transfer with the oldest prediction
      if (dst_valid && dst_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result byte %h run_end %b string_end %b", $time,
                   dst_item.out_byte, dst_item.run_end, dst_item.string_end);
          error_count++;
        end else begin
          want = expected_q.pop_front();
          if (dst_item.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %h actual %h", $time,
                     want.out_byte, dst_item.out_byte);
            error_count++;
          end
          if (dst_item.run_end !== want.run_end) begin
            $display("%0t: run_end expected %b actual %b", $time,
                     want.run_end, dst_item.run_end);
            error_count++;
          end
          if (dst_item.string_end !== want.string_end) begin
            $display("%0t: string_end expected %b actual %b", $time,
                     want.string_end, dst_item.string_end);
            error_count++;
          end
        end
      end
    end
    results_due = expected_q.size();
  end

endmodule

@@ tb/escape_sequence_expander_test.sv @@
// Top of the escape sequence expander test: clock, reset, stimulus and verdict.
module escape_sequence_expander_test;
  import ese_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 60;
  localparam int RANDOM_ITEMS = 400;
  localparam int DRAIN_CYCLES = 20;

  logic clk;
  logic rst;

  ese_stream_if #(.payload_t(in_item_t))  src_ch ();
  ese_stream_if #(.payload_t(out_item_t)) dst_ch ();

  int fail_count;
  int results_due;
  int sent_count;
  bit flat_out;       // no idling on either side
  bit sink_hold_req;  // ask the receiver for one long hold-off

  logic [7:0] text_q[$];

  escape_sequence_expander i_dut (
    .clk (clk),
    .rst (rst),
    .src (src_ch),
    .dst (dst_ch)
  );

  escape_expansion_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .src_valid   (src_ch.valid),
    .src_ready   (src_ch.ready),
    .src_item    (src_ch.payload),
    .dst_valid   (dst_ch.valid),
    .dst_ready   (dst_ch.ready),
    .dst_item    (dst_ch.payload),
    .error_count (fail_count),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("escape_sequence_expander_test NOT OK");
    $finish;
  end

  // Offer one source byte after a random gap and hold it until it transfers
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = flat_out ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      src_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    src_ch.valid   <= 1'b1;
    src_ch.payload <= in_item_t'{in_byte: b, last_byte: last};
    @(posedge clk);
    while (!src_ch.ready) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], i == s.len() - 1);
    end
  endtask

  // Build a string mostly from well-formed escapes with random content
  task automatic build_random_text();
    logic [7:0] simple_esc [9];
    int pieces;
    int kind;
    int n;
    logic [3:0] nib;
    simple_esc = '{CH_LA, CH_LB, CH_LF, CH_LN, CH_LR, CH_LT, CH_LV, CH_BACKSLASH,
                   CH_QUESTION};
    text_q.delete();
    pieces = $urandom_range(1, 4);
    repeat (pieces) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1: text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        2:    text_q.push_back(8'($urandom_range(1, 255)));
        3, 4: begin
          text_q.push_back(CH_BACKSLASH);
          text_q.push_back(simple_esc[$urandom_range(0, 8)]);
        end
        5: begin
          text_q.push_back(CH_BACKSLASH);
          text_q.push_back(CH_LX);
          n = $urandom_range(0, 3);
          repeat (n) begin
            nib = 4'($urandom_range(0, 15));
            if (nib < 10) begin
              text_q.push_back(CH_ZERO + 8'(nib));
            end else begin
              text_q.push_back(($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(nib) - 8'd10);
            end
          end
        end
        6, 7: begin
          text_q.push_back(CH_BACKSLASH);
          n = $urandom_range(1, 3);
          repeat (n) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
        end
        8: begin
          text_q.push_back(CH_BACKSLASH);
          text_q.push_back(8'($urandom_range(1, 255)));
        end
        default: text_q.push_back(CH_BACKSLASH);
      endcase
    end
  endtask

  // Result side: random stall before each transfer, one long hold-off on request
  initial begin
    int stall;
    dst_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        dst_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = flat_out ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        dst_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      dst_ch.ready <= 1'b1;
      @(posedge clk);
      while (!dst_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Source side and verdict
  initial begin
    int string_idx;
    rst = 1'b1;
    src_ch.valid = 1'b0;
    src_ch.payload = '0;
    flat_out = 1'b0;
    sink_hold_req = 1'b0;
    sent_count = 0;
    // Hold reset, then release it at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: byte extremes, escapes, hex, octal and end-of-string cases
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("\\n\\?");
    send_text("\\x\\xfF3");
    send_text("\\377");
    send_text("\\12\\q");
    send_text("\\");
    send_text("\\5");

    // Random strings with pressure phases along the way
    string_idx = 0;
    while (sent_count < RANDOM_ITEMS) begin
      if (string_idx == 8) begin
        flat_out = 1'b1;
        sink_hold_req = 1'b1;
      end
      if (string_idx == 14) flat_out = 1'b0;
      if (string_idx == 20) begin
        // Pause until every result is back
        src_ch.valid <= 1'b0;
        @(negedge clk);
        while (results_due != 0) @(negedge clk);
      end
      if (string_idx == 30) flat_out = 1'b1;
      if (string_idx == 37) flat_out = 1'b0;
      build_random_text();
      foreach (text_q[i]) begin
        send_byte(text_q[i], i == text_q.size() - 1);
      end
      string_idx++;
    end
    src_ch.valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("escape_sequence_expander_test OK");
    end else begin
      $display("escape_sequence_expander_test NOT OK");
    end
    $finish;
  end

endmodule
